>>> rtl/core/chm_pkg.sv
// Shared types and constants of the chained hash map engine.
// Depends on nothing; imported by chm_ram users and the top level.
package chm_pkg;

    localparam int BUCKETS = 32;
    localparam int ENTRIES = 128;

    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PTR_W = $clog2(ENTRIES + 1);
    localparam int CNT_W = 8;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      found_value;
        logic [CNT_W-1:0] element_count;
        logic             table_empty;
    } t_out_word;

    typedef struct packed {
        logic [31:0]      key;
        logic [31:0]      value;
        logic [PTR_W-1:0] link;
    } t_entry;

endpackage

>>> rtl/core/chm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/chained_hash_map_engine.sv
// Chained hash map engine: insert, remove, find and clear on a bucketed key/value pool.
// Steps: clear goes straight to S_EMIT; others read the bucket head (S_HEAD), walk
// the chain (S_WALK), then S_ALLOC or S_REM1/S_REM2, then S_EMIT; one command at a time.
// Reset (synchronous, active low) empties all buckets and rebuilds the free list at once
// through per-entry valid bits; no clearing pass is needed.
// Depends on chm_pkg and chm_ram.
module chained_hash_map_engine
    import chm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);
    typedef enum logic [2:0] {
        S_IDLE, S_HEAD, S_WALK, S_ALLOC, S_REM1, S_REM2, S_EMIT
    } t_state;

    t_state            r_state;
    logic [1:0]        r_cmd;
    logic [31:0]       r_key;
    logic [31:0]       r_value;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_prev;
    t_entry            r_prev_word;
    t_entry            r_hit_word;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [PTR_W-1:0]  r_free;
    logic [PTR_W-1:0]  r_count;
    logic [1:0]        r_status;
    logic [31:0]       r_found;
    logic              r_out_valid;
    t_out_word         r_out;
    logic [BUCKETS-1:0] r_bvalid;
    logic [ENTRIES-1:0] r_evalid;
    logic              r_brd_vld;
    logic              r_erd_vld;
    logic [IDX_W-1:0]  r_erd_addr;

    // RAM ports
    logic              b_we, b_re;
    logic [BKT_W-1:0]  b_waddr, b_raddr;
    logic [PTR_W-1:0]  b_wdata, b_rdata;
    logic              e_we, e_re;
    logic [IDX_W-1:0]  e_waddr, e_raddr;
    t_entry            e_wdata, e_rdata;

    logic              accept;
    logic              out_free;
    logic [BKT_W-1:0]  bkt;
    logic [PTR_W-1:0]  head_now;
    t_entry            ent_word;
    logic              key_hit;
    logic              walk_hit, walk_next, miss_now, hit_now, alloc_rd;
    logic [CNT_W-1:0]  count_out;

    chm_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_bucket_ram (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_waddr(b_waddr),
        .i_wdata(b_wdata),
        .i_re   (b_re),
        .i_raddr(b_raddr),
        .o_rdata(b_rdata)
    );

    chm_ram #(.WIDTH($bits(t_entry)), .DEPTH(ENTRIES)) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (e_we),
        .i_waddr(e_waddr),
        .i_wdata(e_wdata),
        .i_re   (e_re),
        .i_raddr(e_raddr),
        .o_rdata(e_rdata)
    );

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign bkt      = r_key[BKT_W-1:0];

    // Never-written bucket reads as empty; never-written entry sits on the
    // initial free list and links to its successor.
    assign head_now = r_brd_vld ? b_rdata : NIL;
    always_comb begin
        ent_word = e_rdata;
        if (!r_erd_vld) begin
            ent_word.key   = '0;
            ent_word.value = '0;
            ent_word.link  = PTR_W'(r_erd_addr) + PTR_W'(1);
        end
    end

    assign key_hit   = (ent_word.key == r_key);
    assign walk_hit  = (r_state == S_WALK) && key_hit;
    assign walk_next = (r_state == S_WALK) && !key_hit && (ent_word.link != NIL);
    assign miss_now  = ((r_state == S_HEAD) && (head_now == NIL)) ||
                       ((r_state == S_WALK) && !key_hit && (ent_word.link == NIL));
    assign hit_now   = walk_hit;
    assign alloc_rd  = miss_now && (r_cmd == CMD_INSERT) && (r_free != NIL);

    // Memory port control
    always_comb begin
        b_re    = accept && (i_in_word.cmd != CMD_CLEAR);
        b_raddr = i_in_word.key[BKT_W-1:0];
        b_we    = 1'b0;
        b_waddr = bkt;
        b_wdata = r_free;
        e_re    = ((r_state == S_HEAD) && (head_now != NIL)) || walk_next || alloc_rd;
        e_raddr = r_free[IDX_W-1:0];
        e_we    = 1'b0;
        e_waddr = r_free[IDX_W-1:0];
        e_wdata = '{key: r_key, value: r_value, link: r_head};
        if ((r_state == S_HEAD) && (head_now != NIL)) begin
            e_raddr = head_now[IDX_W-1:0];
        end else if (walk_next) begin
            e_raddr = ent_word.link[IDX_W-1:0];
        end
        case (r_state)
            S_ALLOC: begin
                e_we = 1'b1;
                b_we = 1'b1;
            end
            S_REM1: begin
                // unlink the hit entry from its predecessor or the bucket head
                if (r_prev == NIL) begin
                    b_we    = 1'b1;
                    b_wdata = r_hit_word.link;
                end else begin
                    e_we    = 1'b1;
                    e_waddr = r_prev[IDX_W-1:0];
                    e_wdata = '{key: r_prev_word.key, value: r_prev_word.value,
                                link: r_hit_word.link};
                end
            end
            S_REM2: begin
                // push the freed entry onto the free list
                e_we    = 1'b1;
                e_waddr = r_hit_idx;
                e_wdata = '{key: r_hit_word.key, value: r_hit_word.value, link: r_free};
            end
            default: begin
            end
        endcase
    end

    assign count_out = (32'(r_count) > 32'd255) ? 8'hFF : CNT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_bvalid    <= '0;
            r_evalid    <= '0;
            r_brd_vld   <= 1'b0;
            r_erd_vld   <= 1'b0;
        end else begin
            // drop the taken word unless a new one is loaded below
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            if (b_re) begin
                r_brd_vld <= r_bvalid[b_raddr];
            end
            if (e_re) begin
                r_erd_vld  <= r_evalid[e_raddr];
                r_erd_addr <= e_raddr;
            end
            if (b_we) begin
                r_bvalid[b_waddr] <= 1'b1;
            end
            if (e_we) begin
                r_evalid[e_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_in_word.cmd;
                        r_key    <= i_in_word.key;
                        r_value  <= i_in_word.value;
                        r_status <= ST_DONE;
                        r_found  <= '0;
                        r_prev   <= NIL;
                        if (i_in_word.cmd == CMD_CLEAR) begin
                            // drop every chain and rebuild the free list at once
                            r_bvalid <= '0;
                            r_evalid <= '0;
                            r_free   <= '0;
                            r_count  <= '0;
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD, S_WALK: begin
                    if (r_state == S_HEAD) begin
                        r_head <= head_now;
                    end
                    if (walk_next) begin
                        r_prev      <= PTR_W'(r_erd_addr);
                        r_prev_word <= ent_word;
                    end
                    if (hit_now) begin
                        r_hit_word <= ent_word;
                        r_hit_idx  <= r_erd_addr;
                        case (r_cmd)
                            CMD_INSERT: begin
                                r_status <= ST_MISS;
                                r_state  <= S_EMIT;
                            end
                            CMD_FIND: begin
                                r_found <= ent_word.value;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_state <= S_REM1;
                            end
                        endcase
                    end else if (miss_now) begin
                        if (alloc_rd) begin
                            r_state <= S_ALLOC;
                        end else begin
                            r_status <= (r_cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
                            r_state  <= S_EMIT;
                        end
                    end else if (r_state == S_HEAD) begin
                        r_state <= S_WALK;
                    end
                end
                S_ALLOC: begin
                    // ent_word is the free-list head; advance past it
                    r_free  <= ent_word.link;
                    r_count <= r_count + PTR_W'(1);
                    r_state <= S_EMIT;
                end
                S_REM1: begin
                    r_state <= S_REM2;
                end
                S_REM2: begin
                    r_free  <= PTR_W'(r_hit_idx);
                    if (r_count != '0) begin
                        r_count <= r_count - PTR_W'(1);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{status: r_status, found_value: r_found,
                                         element_count: count_out,
                                         table_empty: (r_count == '0)};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ENTRIES)
        else $error("stored count above pool size");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |=> (r_count == $past(r_count) + PTR_W'(1)))
        else $error("insert did not advance the count");

    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!e_we && !b_we))
        else $error("memory write while taking a new word");

    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> (r_free != NIL))
        else $error("allocation from an empty free list");
endmodule
